[hdl/assert_macros.svh]
// Assertion macros used by target_sum_way_counter.
// No dependencies; define NO_ASSERTIONS to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define TSWC_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("tswc assertion failed");
// next-cycle implication
`define TSWC_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("tswc assertion failed");
`else
`define TSWC_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define TSWC_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif

`endif

[hdl/tswc_pkg.sv]
// Package for the target-sum way counter: field widths, count limits
// and the sequencer state type. No dependencies.
`default_nettype none

package tswc_pkg;

    localparam int VALUE_W   = 11;
    localparam int TARGET_W  = 12;
    localparam int COUNT_W   = 21;
    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 24;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
    localparam logic [COUNT_W-1:0] COUNT_ONE = {{(COUNT_W-1){1'b0}}, 1'b1};

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SWEEP,
        ST_DRAIN,
        ST_FINAL
    } t_state;

endpackage

`default_nettype wire

[hdl/tswc_ram.sv]
// Generic RAM: one write port, two read ports, registered read data.
// No dependencies.
`default_nettype none

module tswc_ram #(
    parameter int WIDTH = 21,
    parameter int DEPTH = 2049,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_wr_en,
    input  wire logic [AW-1:0]    i_wr_addr,
    input  wire logic [WIDTH-1:0] i_wr_data,
    input  wire logic [AW-1:0]    i_rd_addr_a,
    output logic      [WIDTH-1:0] o_rd_data_a,
    input  wire logic [AW-1:0]    i_rd_addr_b,
    output logic      [WIDTH-1:0] o_rd_data_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data_a <= mem[i_rd_addr_a];
        o_rd_data_b <= mem[i_rd_addr_b];
    end

endmodule

`default_nettype wire

[hdl/target_sum_way_counter.sv]
// Channel   Dir  Signals                             Words
// s_axis    in   tvalid/tready/tdata/tlast           one number of the set
// m_axis    out  tvalid/tready/tdata/tuser           way count at end of set
// cfg       in   wr_en/wr_data                       target sum
//
// Each number rebuilds the whole count store: 2*MAX_SUM+1 entries, one per
// cycle, reading two entries of the old bank and writing one of the other bank.
// The last number of a set writes the cleared pattern before the result is
// loaded. After reset a clearing pass runs before the first word is taken.
// A stalled result holds in the output register; the next set's numbers are
// taken meanwhile.
// Depends on tswc_pkg, tswc_ram and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module target_sum_way_counter #(
    parameter int MAX_SUM   = 1024,
    parameter int MAX_ITEMS = 20
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // tdata: [10:0] value, [15:11] zero
    input  wire logic [tswc_pkg::S_TDATA_W-1:0]  i_s_axis_tdata,
    input  wire logic                            i_s_axis_tlast,
    input  wire logic                            i_s_axis_tvalid,
    output logic                                 o_s_axis_tready,
    // tdata: [20:0] ways, [23:21] zero
    output logic      [tswc_pkg::M_TDATA_W-1:0]  o_m_axis_tdata,
    // tuser: [0] error
    output logic                                 o_m_axis_tuser,
    output logic                                 o_m_axis_tvalid,
    input  wire logic                            i_m_axis_tready,
    input  wire logic                            i_cfg_wr_en,
    input  wire logic [tswc_pkg::TARGET_W-1:0]   i_cfg_wr_data
);

    localparam int SPAN = 2 * MAX_SUM + 1;
    localparam int AW   = $clog2(SPAN);
    localparam int SW   = ((AW > tswc_pkg::VALUE_W) ? AW : tswc_pkg::VALUE_W) + 2;
    localparam int CW   = $clog2(MAX_ITEMS + 1);
    localparam int CNTW = tswc_pkg::COUNT_W;

    localparam logic [AW-1:0] T_LAST = AW'(SPAN - 1);
    localparam logic [AW-1:0] T_MID  = AW'(MAX_SUM);
    localparam logic [SW-1:0] SPAN_S = SW'(SPAN);
    localparam logic [SW-1:0] MAX_S  = SW'(MAX_SUM);

    tswc_pkg::t_state r_state, n_state;

    logic signed [tswc_pkg::TARGET_W-1:0] r_target;
    logic [tswc_pkg::VALUE_W-1:0]  r_v, n_v;
    logic                          r_last, n_last;
    logic [AW-1:0]                 r_t, n_t;
    logic [CW-1:0]                 r_cnt, n_cnt;
    logic                          r_err, n_err;
    logic                          r_bank, n_bank;
    logic                          r_nz, n_nz;
    logic                          r_nz_acc, n_nz_acc;
    logic [CNTW-1:0]               r_ways, n_ways;
    logic                          r_ovalid, n_ovalid;
    logic [CNTW-1:0]               r_oways, n_oways;
    logic                          r_oerr, n_oerr;

    // read stage
    logic                          r_p_vld, n_p_vld;
    logic [AW-1:0]                 r_p_t, n_p_t;
    logic                          r_p_aok, n_p_aok;
    logic                          r_p_bok, n_p_bok;
    logic                          r_p_aerr, n_p_aerr;
    logic                          r_p_berr, n_p_berr;
    logic                          r_p_fill, n_p_fill;

    logic                          s_acc;
    logic [SW-1:0]                 t_ext, v_ext, v2_ext, sum_a, sum_t2v, val_ext;
    logic                          a_ok, b_ok;
    logic [AW-1:0]                 rd_addr_a, rd_addr_b;
    logic [CNTW-1:0]               b0_a, b0_b, b1_a, b1_b, rd_a, rd_b, c_a, c_b;
    logic [CNTW:0]                 sum_ab;
    logic                          sat;
    logic [CNTW-1:0]               new_cnt, wr_data;
    logic                          err_now, nz_next;
    logic                          tgt_ok;
    int                            tgt_int;
    logic [AW-1:0]                 tgt_idx;
    logic                          issue, fill;
    logic                          st_sweep, st_drain, st_final, final_load;

    assign s_acc = i_s_axis_tvalid && o_s_axis_tready;

    assign st_sweep   = (r_state == tswc_pkg::ST_SWEEP);
    assign st_drain   = (r_state == tswc_pkg::ST_DRAIN);
    assign st_final   = (r_state == tswc_pkg::ST_FINAL);
    assign final_load = st_final && (!r_ovalid || i_m_axis_tready);

    // read addresses for new[t] = old[t+v] + old[t-v]
    assign t_ext   = SW'(r_t);
    assign v_ext   = SW'(r_v);
    assign v2_ext  = v_ext << 1;
    assign sum_a   = t_ext + v_ext;
    assign sum_t2v = t_ext + v2_ext;
    assign a_ok    = sum_a < SPAN_S;
    assign b_ok    = t_ext >= v_ext;
    assign rd_addr_a = a_ok ? sum_a[AW-1:0] : '0;
    assign rd_addr_b = b_ok ? AW'(t_ext - v_ext) : '0;

    tswc_ram #(.WIDTH(CNTW), .DEPTH(SPAN)) u_bank0 (
        .i_clk       (i_clk),
        .i_wr_en     (r_p_vld && r_bank),
        .i_wr_addr   (r_p_t),
        .i_wr_data   (wr_data),
        .i_rd_addr_a (rd_addr_a),
        .o_rd_data_a (b0_a),
        .i_rd_addr_b (rd_addr_b),
        .o_rd_data_b (b0_b)
    );

    tswc_ram #(.WIDTH(CNTW), .DEPTH(SPAN)) u_bank1 (
        .i_clk       (i_clk),
        .i_wr_en     (r_p_vld && !r_bank),
        .i_wr_addr   (r_p_t),
        .i_wr_data   (wr_data),
        .i_rd_addr_a (rd_addr_a),
        .o_rd_data_a (b1_a),
        .i_rd_addr_b (rd_addr_b),
        .o_rd_data_b (b1_b)
    );

    // combine stage
    assign rd_a    = r_bank ? b1_a : b0_a;
    assign rd_b    = r_bank ? b1_b : b0_b;
    assign c_a     = r_p_aok ? rd_a : '0;
    assign c_b     = r_p_bok ? rd_b : '0;
    assign sum_ab  = {1'b0, c_a} + {1'b0, c_b};
    assign sat     = sum_ab[CNTW];
    assign new_cnt = sat ? tswc_pkg::COUNT_MAX : sum_ab[CNTW-1:0];
    // last word of a set writes the cleared pattern instead of the new counts
    assign wr_data = r_p_fill ? ((r_p_t == T_MID) ? tswc_pkg::COUNT_ONE : '0) : new_cnt;
    assign err_now = r_p_vld && (sat || (r_p_aerr && (c_a != '0)) ||
                                 (r_p_berr && (c_b != '0)));
    assign nz_next = r_nz_acc || (r_p_vld && (wr_data != '0));

    assign tgt_int = int'(r_target);
    assign tgt_ok  = (tgt_int >= -MAX_SUM) && (tgt_int <= MAX_SUM);
    assign tgt_idx = AW'(tgt_int + MAX_SUM);
    assign val_ext = SW'(i_s_axis_tdata[tswc_pkg::VALUE_W-1:0]);

    always_comb begin
        n_state  = r_state;
        n_v      = r_v;
        n_last   = r_last;
        n_t      = r_t;
        n_cnt    = r_cnt;
        n_err    = r_err || err_now;
        n_bank   = r_bank;
        n_nz     = r_nz;
        n_nz_acc = nz_next;
        n_ways   = r_ways;
        n_ovalid = r_ovalid && !i_m_axis_tready;
        n_oways  = r_oways;
        n_oerr   = r_oerr;
        issue    = 1'b0;
        fill     = 1'b0;

        if (r_p_vld && r_p_fill && r_last && tgt_ok && (r_p_t == tgt_idx)) begin
            n_ways = new_cnt;
        end

        unique case (r_state)
            tswc_pkg::ST_CLEAR: begin
                issue = 1'b1;
                fill  = 1'b1;
                if (r_t == T_LAST) begin
                    n_state = tswc_pkg::ST_DRAIN;
                end
            end
            tswc_pkg::ST_IDLE: begin
                if (s_acc) begin
                    n_v      = i_s_axis_tdata[tswc_pkg::VALUE_W-1:0];
                    n_last   = i_s_axis_tlast;
                    n_t      = '0;
                    n_nz_acc = 1'b0;
                    n_ways   = '0;
                    if (r_cnt < CW'(MAX_ITEMS)) begin
                        n_cnt = r_cnt + CW'(1);
                    end else begin
                        n_err = 1'b1;
                    end
                    // every count has a sum that moves out of range when the value exceeds MAX_SUM
                    if ((val_ext > MAX_S) && r_nz) begin
                        n_err = 1'b1;
                    end
                    n_state = tswc_pkg::ST_SWEEP;
                end
            end
            tswc_pkg::ST_SWEEP: begin
                issue = 1'b1;
                fill  = r_last;
                if (r_t == T_LAST) begin
                    n_state = tswc_pkg::ST_DRAIN;
                end
            end
            tswc_pkg::ST_DRAIN: begin
                n_bank  = !r_bank;
                n_nz    = nz_next;
                n_state = r_last ? tswc_pkg::ST_FINAL : tswc_pkg::ST_IDLE;
            end
            tswc_pkg::ST_FINAL: begin
                if (final_load) begin
                    n_ovalid = 1'b1;
                    n_oways  = r_ways;
                    n_oerr   = r_err;
                    n_err    = 1'b0;
                    n_cnt    = '0;
                    n_last   = 1'b0;
                    n_state  = tswc_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = tswc_pkg::ST_IDLE;
            end
        endcase

        if (issue && (r_t != T_LAST)) begin
            n_t = r_t + AW'(1);
        end
        n_p_vld  = issue;
        n_p_t    = r_t;
        n_p_fill = fill;
        n_p_aok  = st_sweep && a_ok;
        n_p_bok  = st_sweep && b_ok;
        n_p_aerr = sum_t2v >= SPAN_S;
        n_p_berr = t_ext < v2_ext;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tswc_pkg::ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target <= '0;
            r_last   <= 1'b0;
            r_t      <= '0;
            r_cnt    <= '0;
            r_err    <= 1'b0;
            r_bank   <= 1'b0;
            r_nz     <= 1'b0;
            r_nz_acc <= 1'b0;
            r_ovalid <= 1'b0;
            r_p_vld  <= 1'b0;
            r_p_fill <= 1'b0;
            r_p_aok  <= 1'b0;
            r_p_bok  <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_target <= i_cfg_wr_data;
            end
            r_last   <= n_last;
            r_t      <= n_t;
            r_cnt    <= n_cnt;
            r_err    <= n_err;
            r_bank   <= n_bank;
            r_nz     <= n_nz;
            r_nz_acc <= n_nz_acc;
            r_ovalid <= n_ovalid;
            r_p_vld  <= n_p_vld;
            r_p_fill <= n_p_fill;
            r_p_aok  <= n_p_aok;
            r_p_bok  <= n_p_bok;
        end
    end

    always_ff @(posedge i_clk) begin
        r_v      <= n_v;
        r_ways   <= n_ways;
        r_oways  <= n_oways;
        r_oerr   <= n_oerr;
        r_p_t    <= n_p_t;
        r_p_aerr <= n_p_aerr;
        r_p_berr <= n_p_berr;
    end

    assign o_s_axis_tready = (r_state == tswc_pkg::ST_IDLE);
    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = tswc_pkg::M_TDATA_W'(r_oways);
    assign o_m_axis_tuser  = r_oerr;

    `TSWC_ASSERT_NXT(a_accept_starts_sweep, i_clk, i_rst_n, s_acc, st_sweep && (r_t == '0))
    `TSWC_ASSERT_IMP(a_write_in_range, i_clk, i_rst_n, r_p_vld, r_p_t <= T_LAST)
    `TSWC_ASSERT_NXT(a_drain_flips_bank, i_clk, i_rst_n, st_drain, r_bank != $past(r_bank))
    `TSWC_ASSERT_NXT(a_final_loads, i_clk, i_rst_n, final_load, o_s_axis_tready && r_ovalid)

endmodule

`default_nettype wire

[tb/target_sum_way_counter_test.sv]
// Self-checking bench for target_sum_way_counter: streams sets of numbers,
// predicts the way count and error flag of each set, and checks every result word.
// Depends on tswc_pkg and the target_sum_way_counter RTL.
module target_sum_way_counter_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int VALUE_W   = tswc_pkg::VALUE_W;
    localparam int COUNT_W   = tswc_pkg::COUNT_W;
    localparam int TARGET_W  = tswc_pkg::TARGET_W;
    localparam int S_TDATA_W = tswc_pkg::S_TDATA_W;
    localparam int M_TDATA_W = tswc_pkg::M_TDATA_W;

    localparam int MAX_SUM   = 1024;
    localparam int MAX_ITEMS = 20;
    localparam int SPAN      = 2 * MAX_SUM + 1;
    localparam int PHASES    = 9;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               last;
    } t_number_word;

    typedef struct packed {
        logic [COUNT_W-1:0] ways;
        logic               error;
    } t_tally;

    logic clk;
    logic rst_n = 1'b0;

    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 s_tlast  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 o_s_axis_tready;
    logic [M_TDATA_W-1:0] o_m_axis_tdata;
    logic                 o_m_axis_tuser;
    logic                 o_m_axis_tvalid;
    logic                 m_ready  = 1'b0;
    logic                 cfg_wr_en   = 1'b0;
    logic [TARGET_W-1:0]  cfg_wr_data = '0;

    // predictor state: one count per running sum, -MAX_SUM at index 0
    logic [COUNT_W-1:0]         way_count [SPAN];
    logic                       set_error;
    int                         numbers_in_set;
    logic signed [TARGET_W-1:0] target_reg;

    t_number_word pending_numbers[$];
    t_tally       expected_tallies[$];
    int           numbers_queued = 0;
    int           numbers_taken  = 0;
    int           fault_count    = 0;
    int           send_idle_pct  = 0;
    int           recv_idle_pct  = 0;
    int           send_hold      = 0;
    int           recv_hold      = 0;

    target_sum_way_counter #(
        .MAX_SUM   (MAX_SUM),
        .MAX_ITEMS (MAX_ITEMS)
    ) dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tdata  (s_tdata),      // [10:0] value, [15:11] zero
        .i_s_axis_tlast  (s_tlast),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata), // [20:0] ways, [23:21] zero
        .o_m_axis_tuser  (o_m_axis_tuser), // [0] error
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_ready),
        .i_cfg_wr_en     (cfg_wr_en),
        .i_cfg_wr_data   (cfg_wr_data)
    );

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic void clear_counts();
        foreach (way_count[i]) way_count[i] = '0;
        way_count[MAX_SUM] = tswc_pkg::COUNT_ONE;
        set_error      = 1'b0;
        numbers_in_set = 0;
    endfunction

    // Spread every count to sum-v and sum+v; drop sums past the range.
    function automatic void absorb_number(input logic [VALUE_W-1:0] value);
        logic [COUNT_W-1:0] fresh [SPAN];
        logic [COUNT_W:0]   total;
        int i;
        int k;
        int dest;
        if (numbers_in_set < MAX_ITEMS) numbers_in_set++;
        else set_error = 1'b1;
        foreach (fresh[j]) fresh[j] = '0;
        for (i = 0; i < SPAN; i++) begin
            if (way_count[i] != '0) begin
                for (k = 0; k < 2; k++) begin
                    dest = (k == 0) ? i - int'(value) : i + int'(value);
                    if (dest < 0 || dest >= SPAN) begin
                        set_error = 1'b1;
                    end else begin
                        total = {1'b0, fresh[dest]} + {1'b0, way_count[i]};
                        if (total > {1'b0, tswc_pkg::COUNT_MAX}) begin
                            fresh[dest] = tswc_pkg::COUNT_MAX;
                            set_error   = 1'b1;
                        end else begin
                            fresh[dest] = total[COUNT_W-1:0];
                        end
                    end
                end
            end
        end
        foreach (way_count[j]) way_count[j] = fresh[j];
    endfunction

    function automatic t_tally tally_set();
        t_tally tally;
        int goal;
        goal = target_reg;
        tally.ways  = (goal >= -MAX_SUM && goal <= MAX_SUM) ? way_count[goal + MAX_SUM] : '0;
        tally.error = set_error;
        clear_counts();
        return tally;
    endfunction

    function automatic logic [VALUE_W-1:0] pick_number();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55) return VALUE_W'($urandom_range(0, 15));
        else if (roll < 75) return VALUE_W'($urandom_range(0, 200));
        else if (roll < 88) return VALUE_W'($urandom_range(0, 1024));
        else if (roll < 92) return VALUE_W'(MAX_SUM);
        else return VALUE_W'($urandom_range(0, 2047));
    endfunction

    task automatic queue_number(input logic [VALUE_W-1:0] value, input bit last);
        t_number_word word;
        word.value = value;
        word.last  = last;
        pending_numbers.push_back(word);
        numbers_queued++;
    endtask

    // With aim set and the gap within 2047, the final number closes the gap to
    // the target so one sign choice reaches it.
    task automatic queue_set(input int len, input bit aim);
        int walk;
        int goal;
        int i;
        logic [VALUE_W-1:0] v;
        walk = 0;
        goal = target_reg;
        for (i = 0; i < len; i++) begin
            v = pick_number();
            if (aim && i == len - 1 && goal - walk >= -2047 && goal - walk <= 2047) begin
                v = (goal >= walk) ? VALUE_W'(goal - walk) : VALUE_W'(walk - goal);
            end else if ($urandom_range(0, 1) == 1) begin
                walk += v;
            end else begin
                walk -= v;
            end
            queue_number(v, i == len - 1);
        end
    endtask

    task automatic write_target(input logic signed [TARGET_W-1:0] target);
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= target;
        target_reg   = target;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    // sender: hold a word until taken, then present the next one or idle
    always @(posedge clk) begin
        if (!rst_n) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || o_s_axis_tready) begin
            if (send_hold > 0) begin
                send_hold <= send_hold - 1;
                s_tvalid  <= 1'b0;
            end else if (pending_numbers.size() != 0
                         && $urandom_range(0, 99) >= send_idle_pct) begin
                s_tvalid <= 1'b1;
                s_tdata  <= {{(S_TDATA_W-VALUE_W){1'b0}}, pending_numbers[0].value};
                s_tlast  <= pending_numbers[0].last;
                void'(pending_numbers.pop_front());
            end else begin
                s_tvalid <= 1'b0;
                // now and then a gap that can outlast a whole sweep
                if (pending_numbers.size() != 0 && send_idle_pct != 0
                    && $urandom_range(0, 3) == 0) begin
                    send_hold <= $urandom_range(1, 4500);
                end
            end
        end
    end

    // receiver backpressure
    always @(posedge clk) begin
        if (recv_hold > 0) begin
            recv_hold <= recv_hold - 1;
            m_ready   <= 1'b0;
        end else if ($urandom_range(0, 99) < recv_idle_pct) begin
            m_ready <= 1'b0;
            if ($urandom_range(0, 4095) == 0) recv_hold <= $urandom_range(1, 6000);
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge clk) begin
        if (rst_n && s_tvalid && o_s_axis_tready) begin
            absorb_number(s_tdata[VALUE_W-1:0]);
            if (s_tlast) expected_tallies.push_back(tally_set());
            numbers_taken++;
        end
    end

    always @(posedge clk) begin : check_tallies
        t_tally want;
        if (rst_n && o_m_axis_tvalid && m_ready) begin
            if (expected_tallies.size() == 0) begin
                fault_count++;
                $display("%0t ns: unexpected result, expected none, got ways %0d error %0b",
                         $time, o_m_axis_tdata, o_m_axis_tuser);
            end else begin
                want = expected_tallies.pop_front();
                if (o_m_axis_tdata !== {{(M_TDATA_W-COUNT_W){1'b0}}, want.ways}) begin
                    fault_count++;
                    $display("%0t ns: ways mismatch, expected %0d, got %0d",
                             $time, want.ways, o_m_axis_tdata);
                end
                if (o_m_axis_tuser !== want.error) begin
                    fault_count++;
                    $display("%0t ns: error flag mismatch, expected %0b, got %0b",
                             $time, want.error, o_m_axis_tuser);
                end
            end
        end
    end

    initial begin
        logic signed [TARGET_W-1:0] targets [PHASES];
        int phase;
        int queued;
        int len;
        int roll;
        targets = '{TARGET_W'(0), TARGET_W'(1024), TARGET_W'(-1024),
                    TARGET_W'(2047), TARGET_W'(-2048), TARGET_W'(0),
                    TARGET_W'(7), TARGET_W'(-15), TARGET_W'(0)};
        clear_counts();
        target_reg = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        for (phase = 0; phase < PHASES; phase++) begin
            send_idle_pct = (phase < 3) ? 29 : (phase < 6) ? 49 : 0;
            recv_idle_pct = (phase < 3) ? 49 : (phase < 6) ? 29 : 0;
            if (phase == 5) targets[phase] = TARGET_W'($urandom_range(0, 120) - 60);
            if (phase == 8) targets[phase] = TARGET_W'($urandom_range(0, 4095));
            write_target(targets[phase]);
            if (phase == 0) begin
                queue_number(VALUE_W'(0), 1'b1);        // zero doubles the count
                queue_number(VALUE_W'(MAX_SUM), 1'b1);
                queue_number(VALUE_W'(MAX_SUM), 1'b0);  // second step leaves the range
                queue_number(VALUE_W'(MAX_SUM), 1'b1);
                queue_number(VALUE_W'(2047), 1'b1);     // larger than MAX_SUM
                // 21 zeros: count saturates and the set is too long
                for (len = 0; len < MAX_ITEMS + 1; len++)
                    queue_number(VALUE_W'(0), len == MAX_ITEMS);
            end
            queue_set(2, 1'b1);
            queued = 0;
            while (queued < 22) begin
                roll = $urandom_range(0, 99);
                if (roll < 85) len = $urandom_range(1, 8);
                else if (roll < 95) len = $urandom_range(9, MAX_ITEMS);
                else len = $urandom_range(MAX_ITEMS + 1, MAX_ITEMS + 4);
                queue_set(len, $urandom_range(0, 3) == 0);
                queued += len;
            end
            // drain before touching the target again
            while (numbers_taken != numbers_queued || expected_tallies.size() != 0)
                @(posedge clk);
            repeat (SPAN + 8) @(posedge clk);
        end
        if (fault_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin
        #400_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule

[files.f]
+incdir+hdl
hdl/tswc_pkg.sv
hdl/tswc_ram.sv
hdl/target_sum_way_counter.sv
tb/target_sum_way_counter_test.sv
